// File: sv/sha256_byte_stream_hasher_core_macros.svh
// Assertion macros shared by the hasher RTL
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH

// Assert a property on the rising clock edge, held off during reset
`define SHB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that a trigger is followed in the next cycle by a property
`define SHB_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// File: sv/shb_pkg.sv
package shb_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam int unsigned BufDepth  = 64;
	localparam int unsigned HashDepth = 8;
	localparam logic [7:0]  PadByte   = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{
			32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
		};
		return h[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// File: sv/shb_ram.sv
module shb_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/shb_round.sv
`include "sha256_byte_stream_hasher_core_macros.svh"
// One SHA-256 round per cycle while step is high, plus the 16-word message schedule window.
module shb_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,      // take initial working vars
	input  logic [255:0] init_vars,
	input  logic        step,      // run one round
	input  logic [5:0]  rnd,
	input  logic        w_in_en,   // push a word from the buffer (round < 16)
	input  logic [31:0] w_in,
	output logic [255:0] vars
);

	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] w_q [16];
	logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, maj, se, sa;

	// schedule word for this round
	always_comb begin
		s0 = shb_pkg::rotr(w_q[1], 7) ^ shb_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = shb_pkg::rotr(w_q[14], 17) ^ shb_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = w_in_en ? w_in : w_new;
		se = shb_pkg::rotr(e_q, 6) ^ shb_pkg::rotr(e_q, 11) ^ shb_pkg::rotr(e_q, 25);
		sa = shb_pkg::rotr(a_q, 2) ^ shb_pkg::rotr(a_q, 13) ^ shb_pkg::rotr(a_q, 22);
		ch = (e_q & f_q) ^ (~e_q & g_q);
		maj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t1 = h_q + se + ch + shb_pkg::round_k(rnd) + w_cur;
		t2 = sa + maj;
	end

	// advance working variables and schedule window
	always_ff @(posedge clk) begin
		if (load) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= init_vars;
		end else if (step) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
		end
	end

	assign vars = {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};

	`SHB_ASSERT(a_no_load_step, !(load && step), "load and step together")
	`SHB_ASSERT(a_win_early, !(step && w_in_en && rnd[5:4] != 2'd0), "buffer word past round 15")
	`SHB_ASSERT(a_win_late, !(step && !w_in_en && rnd[5:4] == 2'd0), "missing buffer word")

endmodule

// File: sv/sha256_byte_stream_hasher_core.sv
// Channel | Direction | Handshake       | Payload
// in      | into core | in_valid/stall  | in_item (data_byte, byte_present, message_end)
// out     | from core | out_valid/stall | out_item (digest_word, word_index, last_word, length_error)
//
// A byte without end does not stall the input; the byte that fills a block stalls the input
// through compression: loading the hash words, the rounds, then the fold.
// An end item adds one padding write per cycle through byte 63, one or two compressions,
// and a digest (one lead-in read, then one word per cycle from the hash memory while out
// stall is low).
// Reset clears control, count and valid bits of the hash memory; no clearing pass.
// Out stall holds the digest word; input is taken only in the idle state.
`include "sha256_byte_stream_hasher_core_macros.svh"
module sha256_byte_stream_hasher_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  shb_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output shb_pkg::out_item_t out_item
);

	shb_pkg::state_t state_q, state_d;

	logic [60:0] count_q;
	logic        ovf_q;
	logic        ending_q;    // padding in progress for the last block(s)
	logic        len_blk_q;   // current padding block carries the length
	logic [5:0]  pos_q;       // padding write position
	logic [6:0]  cnt_q;       // generic step counter
	logic [7:0]  hv_q;        // hash word holds live value (else initial)

	// byte buffer memory
	logic       b_we;
	logic [5:0] b_wa, b_ra;
	logic [7:0] b_wd, b_rd;
	shb_ram #(.Width(8), .Depth(shb_pkg::BufDepth)) u_buf (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
	);

	// hash word memory
	logic        h_we;
	logic [2:0]  h_wa, h_ra;
	logic [31:0] h_wd, h_rd, h_val;
	shb_ram #(.Width(32), .Depth(shb_pkg::HashDepth)) u_hash (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);
	logic [2:0] h_ra_s1;
	logic       rd_v_s1;
	always_ff @(posedge clk) begin
		h_ra_s1 <= h_ra;
	end
	assign h_val = hv_q[h_ra_s1] ? h_rd : shb_pkg::init_h(h_ra_s1);

	// round unit
	logic         r_load, r_step, r_win;
	logic [255:0] r_init, r_vars;
	logic [5:0]   r_rnd;
	logic [31:0]  w_acc_q, r_w;
	logic [255:0] hsave_q;
	shb_round u_round (
		.clk(clk), .arst_n(arst_n), .load(r_load), .init_vars(r_init), .step(r_step),
		.rnd(r_rnd), .w_in_en(r_win), .w_in(r_w), .vars(r_vars)
	);

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != shb_pkg::ST_IDLE);

	logic [60:0] count_inc;
	assign count_inc = count_q + 61'd1;
	logic [63:0] bits;
	assign bits = {count_q, 3'b000};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shb_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_item.byte_present && count_inc[5:0] == 6'd0) begin
						state_d = shb_pkg::ST_LOAD;
					end else if (in_item.message_end) begin
						state_d = shb_pkg::ST_PAD;
					end
				end
			end
			shb_pkg::ST_PAD: begin
				if (pos_q == 6'd63 || (len_blk_q && pos_q == 6'd55)) begin
					state_d = len_blk_q ? shb_pkg::ST_LEN : shb_pkg::ST_LOAD;
				end
			end
			shb_pkg::ST_LEN:  if (pos_q == 6'd63) state_d = shb_pkg::ST_LOAD;
			shb_pkg::ST_LOAD: if (cnt_q == 7'd8) state_d = shb_pkg::ST_ROUND;
			shb_pkg::ST_ROUND: if (cnt_q == 7'd127) state_d = shb_pkg::ST_FOLD;
			shb_pkg::ST_FOLD: begin
				if (cnt_q == 7'd8) begin
					if (!ending_q) state_d = shb_pkg::ST_IDLE;
					else if (len_blk_q) state_d = shb_pkg::ST_EMIT;
					else state_d = shb_pkg::ST_PAD;
				end
			end
			shb_pkg::ST_EMIT: if (out_acc && out_item.last_word) state_d = shb_pkg::ST_IDLE;
			default: state_d = shb_pkg::ST_IDLE;
		endcase
	end

	// memory and round-unit controls
	// ROUND: cnt 0..127; one byte read per cycle assembles the first 16 words, so
	// rounds 0..15 fire once per assembled word and rounds 16..63 one per cycle.
	logic [5:0] rnd_of;
	logic       rnd_fire;
	always_comb begin
		b_we = 1'b0; b_wa = pos_q; b_wd = 8'h00; b_ra = 6'd0;
		h_we = 1'b0; h_wa = 3'd0; h_wd = h_val; h_ra = 3'd0;
		r_load = 1'b0; r_step = 1'b0; r_win = 1'b0; r_init = hsave_q; r_w = 32'd0;
		rnd_of = 6'd0; rnd_fire = 1'b0;
		unique case (state_q)
			shb_pkg::ST_IDLE: begin
				b_we = in_acc && in_item.byte_present;
				b_wa = count_q[5:0];
				b_wd = in_item.data_byte;
			end
			shb_pkg::ST_PAD: begin
				b_we = 1'b1;
				b_wd = (pos_q == count_q[5:0] && !cnt_q[0]) ? shb_pkg::PadByte : 8'h00;
			end
			shb_pkg::ST_LEN: begin
				b_we = 1'b1;
				b_wd = bits[8*(63 - pos_q) +: 8];
			end
			shb_pkg::ST_LOAD: begin
				h_ra = cnt_q[2:0];
			end
			shb_pkg::ST_ROUND: begin
				b_ra = cnt_q[5:0];
				r_load = (cnt_q == 7'd0);
				// rounds 0..15: byte reads at cnt 0..63, word ready at cnt 4k+4
				// rounds 16..63 at cnt 65..112 step 1
				if (cnt_q >= 7'd4 && cnt_q <= 7'd64 && cnt_q[1:0] == 2'd0) begin
					rnd_fire = 1'b1; r_win = 1'b1;
					rnd_of = 6'(cnt_q[6:2] - 5'd1);
					r_w = {w_acc_q[23:0], b_rd};
				end else if (cnt_q >= 7'd65 && cnt_q <= 7'd112) begin
					rnd_fire = 1'b1;
					rnd_of = 6'(cnt_q - 7'd49);
				end
				r_step = rnd_fire;
				h_ra = 3'd0;
			end
			shb_pkg::ST_FOLD: begin
				h_ra = cnt_q[2:0];
				if (cnt_q != 7'd0) begin
					h_we = 1'b1;
					h_wa = 3'(cnt_q - 7'd1);
					h_wd = h_val + r_vars[32*(8 - cnt_q) +: 32];
				end
			end
			shb_pkg::ST_EMIT: begin
				h_ra = out_acc ? 3'(cnt_q + 7'd1) : cnt_q[2:0];
			end
			default: ;
		endcase
	end
	assign r_rnd = rnd_of;

	assign out_valid = (state_q == shb_pkg::ST_EMIT) && rd_v_s1;
	always_comb begin
		out_item.digest_word  = h_val;
		out_item.word_index   = cnt_q[2:0];
		out_item.last_word    = (cnt_q[2:0] == 3'd7);
		out_item.length_error = ovf_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == shb_pkg::ST_ROUND) begin
			w_acc_q <= {w_acc_q[23:0], b_rd};
		end
		if (state_q == shb_pkg::ST_LOAD && cnt_q != 7'd0) begin
			hsave_q <= {hsave_q[223:0], h_val};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shb_pkg::ST_IDLE;
			count_q <= '0; ovf_q <= 1'b0; ending_q <= 1'b0; len_blk_q <= 1'b0;
			pos_q <= '0; cnt_q <= '0; hv_q <= '0; rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == shb_pkg::ST_EMIT);
			// hold the word counter while a digest word is stalled
			if (state_q != state_d) cnt_q <= '0;
			else if (state_q != shb_pkg::ST_EMIT || out_acc) cnt_q <= cnt_q + 7'd1;
			unique case (state_q)
				shb_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (in_item.byte_present) begin
							count_q <= count_inc;
							if (&count_q) ovf_q <= 1'b1;
						end
						// a byte that fills the block leaves the pad to a fresh block
						if (in_item.message_end) begin
							ending_q <= 1'b1;
							pos_q <= in_item.byte_present ? count_inc[5:0] : count_q[5:0];
							len_blk_q <= !(in_item.byte_present && count_inc[5:0] == 6'd0)
								&& ((in_item.byte_present ? count_inc[5:0]
								: count_q[5:0]) < 6'd56);
						end
					end
				end
				shb_pkg::ST_PAD: pos_q <= pos_q + 6'd1;
				shb_pkg::ST_LEN: pos_q <= pos_q + 6'd1;
				shb_pkg::ST_FOLD: begin
					if (cnt_q != 7'd0) hv_q[3'(cnt_q - 7'd1)] <= 1'b1;
					if (cnt_q == 7'd8 && ending_q) begin
						len_blk_q <= 1'b1;
						pos_q <= 6'd0;
					end
				end
				shb_pkg::ST_EMIT: begin
					// drop message state after the last digest word
					if (out_acc && out_item.last_word) begin
						count_q <= '0; ovf_q <= 1'b0; ending_q <= 1'b0;
						len_blk_q <= 1'b0; hv_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	`SHB_ASSERT(a_stall_idle, in_stall == (state_q != shb_pkg::ST_IDLE), "stall mismatch")
	`SHB_ASSERT(a_out_emit, !out_valid || state_q == shb_pkg::ST_EMIT, "output outside emit")
	`SHB_ASSERT(a_no_bwrite_round, !(b_we && state_q == shb_pkg::ST_ROUND), "buffer write in rounds")
	`SHB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled word changed")

endmodule
